FILE: hw/rtl/knn_tilt_zone_classifier_core_defines.svh
// assertion macros for the tilt classifier
`ifndef KNN_TILT_ZONE_CLASSIFIER_CORE_DEFINES_SVH
`define KNN_TILT_ZONE_CLASSIFIER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define KTZ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define KTZ_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define KTZ_ASSERT(label, prop)
`define KTZ_ASSERT_RST(label, prop)
`endif
`endif

FILE: hw/rtl/ktz_pkg.sv
package ktz_pkg;
  localparam int SAMPLES_PER_ZONE_DEF = 64;
  localparam int MAX_K_DEF = 15;
  localparam int NUM_ZONES = 4;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [17:0] PI_Q13 = 18'sd25736;

  localparam logic [1:0] FUNC_TRAIN = 2'd0;
  localparam logic [1:0] FUNC_RAW = 2'd1;
  localparam logic [1:0] FUNC_ANGLE = 2'd2;

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_K = 1'b1;

  function automatic logic signed [17:0] atan_q13(input logic [3:0] i);
    case (i)
      4'd0: atan_q13 = 18'sd6434;
      4'd1: atan_q13 = 18'sd3798;
      4'd2: atan_q13 = 18'sd2007;
      4'd3: atan_q13 = 18'sd1019;
      4'd4: atan_q13 = 18'sd511;
      4'd5: atan_q13 = 18'sd256;
      4'd6: atan_q13 = 18'sd128;
      4'd7: atan_q13 = 18'sd64;
      4'd8: atan_q13 = 18'sd32;
      4'd9: atan_q13 = 18'sd16;
      4'd10: atan_q13 = 18'sd8;
      4'd11: atan_q13 = 18'sd4;
      4'd12: atan_q13 = 18'sd2;
      4'd13: atan_q13 = 18'sd1;
      default: atan_q13 = 18'sd0;
    endcase
  endfunction
endpackage

FILE: hw/rtl/knn_tilt_zone_classifier_core.sv
// Tilt k-nearest-neighbor classifier over four zones. One item at a time:
// in_stall stays high from a transfer until the block is idle again.
// A train item runs a filter step per axis, two CORDIC angles and one table
// write; a CORDIC ends early once its residual is zero. A classify item
// computes two angles (none for given angles), then reads and compares each
// table slot in turn, inserting each entry that qualifies into the sorted
// nearest list one shift at a time, then votes and outputs. A result
// waiting on out_stall holds the next classify item at its output step.
// After reset a clearing pass writes the table to zero; no item is accepted
// until it ends. func 3 and out-of-range slots are dropped with no result.
module knn_tilt_zone_classifier_core
  import ktz_pkg::*;
#(
  parameter int SAMPLES_PER_ZONE = SAMPLES_PER_ZONE_DEF,
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [1:0]         in_zone_label,
  input  logic [5:0]         in_sample_index,
  input  logic signed [15:0] in_pitch_in,
  input  logic signed [15:0] in_roll_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_zone_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data
);
  localparam int TSIZE = NUM_ZONES * SAMPLES_PER_ZONE;
  localparam int AW = $clog2(TSIZE);
  localparam int KW = $clog2(MAX_K + 1);
  localparam int PW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int EW = 34;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FILT, S_ANG0, S_ANG1, S_WRITE,
    S_SCAN, S_INS, S_VOTE, S_OUT
  } state_t;

  state_t state_r;
  logic [16:0] alpha_r;
  logic [3:0] k_r;
  logic signed [15:0] f_r [3];
  logic [1:0] func_r, zone_r;
  logic signed [15:0] ax_r, ay_r, az_r, p_r, q_r;
  logic [AW-1:0] slot_r;
  logic [AW:0] addr_r;
  logic [1:0] fax_r;
  logic [KW-1:0] k_eff_r, cnt_r;
  logic [PW-1:0] pos_r;
  logic [32:0] d_r;
  logic [1:0] dz_r;
  logic [32:0] nd_r [MAX_K];
  logic [1:0] nz_r [MAX_K];
  logic [KW-1:0] vote_r [NUM_ZONES];
  logic [KW-1:0] vi_r;
  logic [1:0] out_zone_r;
  logic out_valid_r;
  logic rd_phase_r;

  // table memory
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  ktz_ram #(.WIDTH(EW), .DEPTH(TSIZE)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic c_start, c_done;
  logic signed [15:0] c_a, c_b, c_ang;
  ktz_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(c_start), .a(c_a), .b(c_b),
    .done(c_done), .angle(c_ang)
  );

  logic in_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_zone_out = out_zone_r;

  // result register loads only once the previous transfer has left
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // filter, one axis per cycle: one 17x16 multiply pair
  logic [16:0] a_eff;
  logic signed [15:0] fv, fo;
  logic signed [35:0] fs, fr;
  assign a_eff = alpha_r[16] ? 17'd65536 : alpha_r;
  always_comb begin
    case (fax_r)
      2'd0: fv = ax_r;
      2'd1: fv = ay_r;
      default: fv = az_r;
    endcase
    fo = f_r[fax_r];
    fs = $signed({1'b0, a_eff}) * 36'(fv)
       + $signed({1'b0, 18'(18'd65536 - 18'(a_eff))}) * 36'(fo) + 36'sd32768;
    fr = fs >>> 16;
  end

  assign c_a = (state_r == S_FILT || state_r == S_ANG0 && !c_done) ?
               ((func_r == FUNC_TRAIN) ? f_r[0] : ax_r) :
               ((func_r == FUNC_TRAIN) ? f_r[1] : ay_r);
  assign c_b = (state_r == S_FILT || state_r == S_ANG0 && !c_done) ?
               ((func_r == FUNC_TRAIN) ? f_r[1] : ay_r) :
               ((func_r == FUNC_TRAIN) ? f_r[2] : az_r);

  logic c_start_r;
  assign c_start = c_start_r;

  // distance of the entry read
  logic signed [16:0] dp, dr;
  logic signed [33:0] dp_sq, dr_sq;
  logic [32:0] dnew;
  assign dp = 17'(p_r) - 17'($signed(rdata[33:18]));
  assign dr = 17'(q_r) - 17'($signed(rdata[17:2]));
  assign dp_sq = 34'(dp) * 34'(dp);
  assign dr_sq = 34'(dr) * 34'(dr);
  assign dnew = dp_sq[32:0] + dr_sq[32:0];

  logic [PW-1:0] kl;
  assign kl = PW'(k_eff_r - KW'(1));

  // majority zone, ties to the lower zone
  logic [1:0] best01, best012, best_zone;
  always_comb begin
    best01 = (vote_r[1] > vote_r[0]) ? 2'd1 : 2'd0;
    best012 = (vote_r[2] > vote_r[best01]) ? 2'd2 : best01;
    best_zone = (vote_r[3] > vote_r[best012]) ? 2'd3 : best012;
  end

  always_comb begin
    we = 1'b0;
    waddr = slot_r;
    wdata = {p_r, c_ang, zone_r};
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      waddr = addr_r[AW-1:0];
      wdata = '0;
    end else if (state_r == S_WRITE) begin
      we = 1'b1;
    end
    raddr = addr_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      alpha_r <= 17'd32768;
      k_r <= 4'd5;
      f_r[0] <= '0; f_r[1] <= '0; f_r[2] <= '0;
      addr_r <= '0;
      out_valid_r <= 1'b0;
      c_start_r <= 1'b0;
      rd_phase_r <= 1'b0;
    end else begin
      c_start_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA: alpha_r <= cfg_data;
          default: k_r <= cfg_data[3:0];
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_zone_r <= best_zone;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == (AW+1)'(TSIZE - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            func_r <= in_func;
            ax_r <= in_accel_x; ay_r <= in_accel_y; az_r <= in_accel_z;
            zone_r <= in_zone_label;
            slot_r <= AW'(32'(in_zone_label) * SAMPLES_PER_ZONE + 32'(in_sample_index));
            p_r <= in_pitch_in; q_r <= in_roll_in;
            fax_r <= 2'd0;
            k_eff_r <= (k_r == 4'd0) ? KW'(1) :
                       (32'(k_r) > MAX_K) ? KW'(MAX_K) : KW'(k_r);
            case (in_func)
              FUNC_TRAIN: begin
                if (32'(in_sample_index) < SAMPLES_PER_ZONE) begin
                  state_r <= S_FILT;
                  if (in_zone_label == 2'd0 && in_sample_index == 6'd0) begin
                    f_r[0] <= '0; f_r[1] <= '0; f_r[2] <= '0;
                  end
                end
              end
              FUNC_RAW: begin
                state_r <= S_ANG0;
                c_start_r <= 1'b1;
              end
              FUNC_ANGLE: begin
                state_r <= S_SCAN;
                addr_r <= '0;
                cnt_r <= '0;
                rd_phase_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_FILT: begin
          if (fr > 36'sd32767) f_r[fax_r] <= 16'sd32767;
          else if (fr < -36'sd32768) f_r[fax_r] <= -16'sd32768;
          else f_r[fax_r] <= 16'(fr);
          fax_r <= fax_r + 2'd1;
          if (fax_r == 2'd2) begin
            state_r <= S_ANG0;
            c_start_r <= 1'b1;
          end
        end
        S_ANG0: begin
          if (c_done) begin
            p_r <= c_ang;
            state_r <= S_ANG1;
            c_start_r <= 1'b1;
          end
        end
        S_ANG1: begin
          if (c_done) begin
            if (func_r == FUNC_TRAIN) state_r <= S_WRITE;
            else begin
              q_r <= c_ang;
              state_r <= S_SCAN;
              addr_r <= '0;
              cnt_r <= '0;
              rd_phase_r <= 1'b0;
            end
          end
        end
        S_WRITE: state_r <= S_IDLE;
        S_SCAN: begin
          // issue read, then evaluate the returned entry
          if (!rd_phase_r) rd_phase_r <= 1'b1;
          else begin
            rd_phase_r <= 1'b0;
            addr_r <= addr_r + 1'b1;
            d_r <= dnew;
            dz_r <= rdata[1:0];
            if (cnt_r == k_eff_r && !(dnew < nd_r[kl])) begin
              if (addr_r == (AW+1)'(TSIZE - 1)) begin
                state_r <= S_VOTE;
                vi_r <= '0;
                for (int z = 0; z < NUM_ZONES; z++) vote_r[z] <= '0;
              end
            end else begin
              pos_r <= (cnt_r < k_eff_r) ? PW'(cnt_r) : kl;
              if (cnt_r < k_eff_r) cnt_r <= cnt_r + 1'b1;
              state_r <= S_INS;
            end
          end
        end
        S_INS: begin
          if (pos_r != '0 && nd_r[pos_r - 1'b1] > d_r) begin
            nd_r[pos_r] <= nd_r[pos_r - 1'b1];
            nz_r[pos_r] <= nz_r[pos_r - 1'b1];
            pos_r <= pos_r - 1'b1;
          end else begin
            nd_r[pos_r] <= d_r;
            nz_r[pos_r] <= dz_r;
            if (addr_r == (AW+1)'(TSIZE)) begin
              state_r <= S_VOTE;
              vi_r <= '0;
              for (int z = 0; z < NUM_ZONES; z++) vote_r[z] <= '0;
            end else state_r <= S_SCAN;
          end
        end
        S_VOTE: begin
          if (vi_r == cnt_r) begin
            state_r <= S_OUT;
          end else begin
            vote_r[nz_r[PW'(vi_r)]] <= vote_r[nz_r[PW'(vi_r)]] + 1'b1;
            vi_r <= vi_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "knn_tilt_zone_classifier_core_defines.svh"
  `KTZ_ASSERT_RST(a_reset_clear, !rst_n |=> state_r == S_CLEAR)
  `KTZ_ASSERT(a_busy_stall, state_r != S_IDLE |-> in_stall)
  `KTZ_ASSERT(a_cnt_bound, (state_r == S_SCAN || state_r == S_INS || state_r == S_VOTE) |-> cnt_r <= k_eff_r)
endmodule

FILE: hw/rtl/ktz_ram.sv
module ktz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/ktz_cordic.sv
// iterative vectoring atan2, one step per cycle
module ktz_cordic
  import ktz_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic               done,
  output logic signed [15:0] angle
);
  // 16-bit inputs grow by less than 2 bits over the steps
  logic signed [19:0] x_r, y_r;
  logic signed [17:0] z_r;
  logic [3:0] i_r;
  logic busy_r, done_r;
  logic signed [19:0] xs, ys;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (b < 0) begin
          x_r <= -20'(b);
          y_r <= -20'(a);
          z_r <= (a >= 0) ? PI_Q13 : -PI_Q13;
        end else begin
          x_r <= 20'(b);
          y_r <= 20'(a);
          z_r <= '0;
        end
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (y_r == 0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (y_r > 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_q13(i_r);
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_q13(i_r);
          end
          i_r <= i_r + 4'd1;
          if (i_r == 4'(CORDIC_STEPS - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  always_comb begin
    if (z_r > PI_Q13) angle = 16'(PI_Q13);
    else if (z_r < -PI_Q13) angle = 16'(-PI_Q13);
    else angle = 16'(z_r);
  end

  `include "knn_tilt_zone_classifier_core_defines.svh"
  `KTZ_ASSERT(a_no_overlap, start |-> !busy_r)
  `KTZ_ASSERT(a_done_pulse, done |=> !done)
  `KTZ_ASSERT(a_done_after_busy, done |-> $past(busy_r))
endmodule

FILE: bench/knn_tilt_zone_classifier_core_checker.sv
module knn_tilt_zone_classifier_core_checker
  import ktz_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [1:0]         in_zone_label,
  input  logic [5:0]         in_sample_index,
  input  logic signed [15:0] in_pitch_in,
  input  logic signed [15:0] in_roll_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_zone_out,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 fail_count,
  output int                 zones_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 4 * SAMPLES_PER_ZONE_DEF;
  localparam int PI_VAL = 25736;

  int arc_tab [16] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0};

  logic [16:0] alpha_reg;
  logic [3:0]  k_reg;
  int          lpf [3];
  int          tab_pitch [SLOTS];
  int          tab_roll [SLOTS];
  logic [1:0]  tab_zone [SLOTS];
  logic [1:0]  zone_q [$];

  function automatic int tilt_atan2(int a, int b);
    int x, y, z, nx, ny;
    x = b;
    y = a;
    z = 0;
    if (a == 0 && b == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_VAL : -PI_VAL;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += arc_tab[i];
      end else if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= arc_tab[i];
      end else begin
        break;
      end
      x = nx;
      y = ny;
    end
    if (z > PI_VAL) z = PI_VAL;
    if (z < -PI_VAL) z = -PI_VAL;
    return z;
  endfunction

  function automatic int smooth_axis(int v, int f, longint a);
    longint s, r;
    s = a * v + (65536 - a) * f + 32768;
    r = s >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  function automatic logic [1:0] vote_zone(int p, int r);
    longint unsigned nd [15];
    logic [1:0] nz [15];
    int k, cnt, pos, best;
    int votes [4];
    longint dp, dr;
    longint unsigned d;
    k = (k_reg == 0) ? 1 : int'(k_reg);
    cnt = 0;
    best = 0;
    votes = '{0, 0, 0, 0};
    for (int i = 0; i < SLOTS; i++) begin
      dp = longint'(p) - tab_pitch[i];
      dr = longint'(r) - tab_roll[i];
      d = dp * dp + dr * dr;
      if (cnt == k && !(d < nd[k - 1])) continue;
      pos = (cnt < k) ? cnt : k - 1;
      while (pos > 0 && nd[pos - 1] > d) begin
        nd[pos] = nd[pos - 1];
        nz[pos] = nz[pos - 1];
        pos--;
      end
      nd[pos] = d;
      nz[pos] = tab_zone[i];
      if (cnt < k) cnt++;
    end
    for (int i = 0; i < cnt; i++) votes[nz[i]]++;
    for (int i = 1; i < 4; i++) if (votes[i] > votes[best]) best = i;
    return best[1:0];
  endfunction

  always @(posedge clk) begin
    int slot;
    longint a;
    if (!rst_n) begin
      alpha_reg <= 17'd32768;
      k_reg <= 4'd5;
      for (int i = 0; i < 3; i++) lpf[i] = 0;
      for (int i = 0; i < SLOTS; i++) begin
        tab_pitch[i] = 0;
        tab_roll[i] = 0;
        tab_zone[i] = 2'd0;
      end
      zone_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ALPHA) alpha_reg <= cfg_data;
        else k_reg <= cfg_data[3:0];
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_TRAIN) begin
          a = (alpha_reg > 17'd65536) ? 65536 : longint'(alpha_reg);
          slot = int'(in_zone_label) * SAMPLES_PER_ZONE_DEF + int'(in_sample_index);
          if (slot == 0) for (int i = 0; i < 3; i++) lpf[i] = 0;
          lpf[0] = smooth_axis(in_accel_x, lpf[0], a);
          lpf[1] = smooth_axis(in_accel_y, lpf[1], a);
          lpf[2] = smooth_axis(in_accel_z, lpf[2], a);
          tab_pitch[slot] = tilt_atan2(lpf[0], lpf[1]);
          tab_roll[slot] = tilt_atan2(lpf[1], lpf[2]);
          tab_zone[slot] = in_zone_label;
        end else if (in_func == FUNC_RAW) begin
          zone_q.push_back(vote_zone(tilt_atan2(in_accel_x, in_accel_y),
                                     tilt_atan2(in_accel_y, in_accel_z)));
        end else if (in_func == FUNC_ANGLE) begin
          zone_q.push_back(vote_zone(in_pitch_in, in_roll_in));
        end
      end
      if (out_valid && !out_stall) begin
        if (zone_q.size() == 0) begin
          $error("zone_out transfer with nothing expected, actual %0d", out_zone_out);
          fail_count <= fail_count + 1;
        end else begin
          if (out_zone_out !== zone_q[0]) begin
            $error("zone_out expected %0d actual %0d", zone_q[0], out_zone_out);
            fail_count <= fail_count + 1;
          end
          void'(zone_q.pop_front());
        end
      end
    end
    zones_pending <= zone_q.size();
  end
endmodule

FILE: bench/tb_knn_tilt_zone_classifier_core.sv
module tb_knn_tilt_zone_classifier_core;
  import ktz_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = FUNC_TRAIN;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic [1:0]         in_zone_label = '0;
  logic [5:0]         in_sample_index = '0;
  logic signed [15:0] in_pitch_in = '0;
  logic signed [15:0] in_roll_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_zone_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_ALPHA;
  logic [16:0]        cfg_data = '0;
  int                 fail_count;
  int                 zones_pending;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_trig = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  knn_tilt_zone_classifier_core DUT (.*);

  knn_tilt_zone_classifier_core_checker u_checker (.*);

  // receiver: random stall, or a long counted hold-off when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("knn_tilt_zone_classifier_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(logic [1:0] f, logic signed [15:0] ax, logic signed [15:0] ay,
                      logic signed [15:0] az, logic [1:0] zn, logic [5:0] idx,
                      logic signed [15:0] p, logic signed [15:0] r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_zone_label <= zn;
    in_sample_index <= idx;
    in_pitch_in <= p;
    in_roll_in <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (zones_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(51472)) - 25736);
  endfunction

  function automatic logic signed [15:0] near_val(int base);
    int v;
    v = base + $signed($urandom_range(4000)) - 2000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic random_items(int count);
    int base [4][3] = '{'{0, 0, 16000}, '{16000, 0, 0}, '{0, 16000, 0}, '{-12000, -12000, -8000}};
    int sel, zn;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      zn = $urandom_range(3);
      if (sel < 40) begin
        send(FUNC_TRAIN, near_val(base[zn][0]), near_val(base[zn][1]), near_val(base[zn][2]),
             zn[1:0], 6'($urandom_range(63)), 16'($urandom), 16'($urandom));
      end else if (sel < 48) begin
        send(FUNC_TRAIN, 16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
             6'($urandom), 16'($urandom), 16'($urandom));
      end else if (sel < 68) begin
        send(FUNC_RAW, near_val(base[zn][0]), near_val(base[zn][1]), near_val(base[zn][2]),
             2'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
      end else if (sel < 75) begin
        send(FUNC_RAW, 16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
             6'($urandom), 16'($urandom), 16'($urandom));
      end else if (sel < 95) begin
        send(FUNC_ANGLE, 16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
             6'($urandom), rand_angle(), rand_angle());
      end else begin
        send(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
             6'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    logic [16:0] alphas [6] = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd1000, 17'd70000};
    logic [3:0]  ks [6] = '{4'd0, 4'd1, 4'd15, 4'd5, 4'd3, 4'd8};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table first: every entry ties at zone zero; then directed corner items
    send(FUNC_ANGLE, 0, 0, 0, 0, 0, 16'sd25736, -16'sd25736);
    send(FUNC_RAW, 0, 0, 0, 0, 0, 0, 0);
    send(FUNC_TRAIN, 0, 0, 0, 2'd0, 6'd0, 0, 0);
    send(FUNC_TRAIN, 16'sh7fff, -16'sh8000, 16'sh7fff, 2'd1, 6'd63, 0, 0);
    send(FUNC_TRAIN, -16'sh8000, -16'sh8000, -16'sh8000, 2'd3, 6'd63, 0, 0);
    send(FUNC_TRAIN, 16'sd100, -16'sd5000, 16'sd0, 2'd2, 6'd10, 0, 0);
    send(FUNC_TRAIN, -16'sd100, -16'sd5000, -16'sd300, 2'd2, 6'd11, 0, 0);
    send(FUNC_TRAIN, 16'sd0, 16'sd20000, -16'sd20000, 2'd1, 6'd5, 0, 0);
    send(FUNC_RAW, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
    send(FUNC_RAW, -16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0, 0);
    send(FUNC_RAW, 16'sd0, -16'sd300, 16'sd0, 0, 0, 0, 0);
    send(FUNC_RAW, -16'sd1, -16'sd300, 16'sd5, 0, 0, 0, 0);
    send(FUNC_ANGLE, 0, 0, 0, 0, 0, -16'sd25736, 16'sd25736);
    send(FUNC_ANGLE, 0, 0, 0, 0, 0, 16'sh7fff, -16'sh8000);
    send(FUNC_ANGLE, 0, 0, 0, 0, 0, 0, 0);
    send(2'd3, 16'sh7fff, 0, 0, 2'd3, 6'd63, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_ALPHA, alphas[ph]);
      write_reg(CFG_K, ks[ph]);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 61; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 61; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      if (ph == 0) hold_trig = ~hold_trig;
      random_items(230);
      drain();
    end

    if (fail_count == 0) begin
      $display("knn_tilt_zone_classifier_core regression: pass");
    end else begin
      $display("knn_tilt_zone_classifier_core regression: fail");
    end
    $finish;
  end
endmodule
